>>> src/hsvsb_pkg.sv
// ----------------------------------------------------------------------------
// hsvsb_pkg
// Shared constants and codes for the HSV saturation / brightness adjust unit.
// ----------------------------------------------------------------------------
package hsvsb_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned HUE_W      = 15;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIV_NUM_W  = 24;
  localparam int unsigned DIV_DEN_W  = 8;
  localparam int unsigned DIV_BPS    = 4;

  localparam logic [HUE_W-1:0] HUE_60  = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_120 = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_240 = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_360 = 15'd23040;

  // Reciprocal multipliers, exact over the value ranges used here
  localparam logic [20:0] RECIP_15  = 21'd1118482;  // ceil(2^24 / 15)
  localparam logic [16:0] RECIP_257 = 17'd65281;    // ceil(2^24 / 257)

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADJUST_MODE = 2'd0,
    REG_GAIN_Q8     = 2'd1
  } cfg_reg_t;

endpackage

>>> src/hsv_saturation_brightness_adjust_unit.sv
// Path: an input beat passes stage 1, the divider stages and stages A to I to the output beat.
// Throughput: one pixel per cycle; the whole pipeline holds while the output beat waits.
// The two hue/saturation dividers set the depth, DIV_BITS_PER_STAGE (default DIV_BPS) quotient bits per stage.
// Reset (rst, synchronous): clears all stage valid bits, adjust_mode and gain_q8.
// ----------------------------------------------------------------------------
// hsv_saturation_brightness_adjust_unit
// RGB to HSV, saturation or value gain with clamping, HSV back to RGB.
// ----------------------------------------------------------------------------
module hsv_saturation_brightness_adjust_unit
  import hsvsb_pkg::*;
#(
  parameter int unsigned DIV_BITS_PER_STAGE = DIV_BPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    in_blue,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_red
);

  localparam int unsigned DIV_STG = (DIV_NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int unsigned NSTG    = DIV_STG + 10;

  logic                     adjust_mode;
  logic signed [GAIN_W-1:0] gain_q8;
  logic [NSTG-1:0]          vld;
  logic                     en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_mode <= 1'b0;
      gain_q8     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADJUST_MODE: adjust_mode <= cfg_data[0];
        REG_GAIN_Q8:     gain_q8     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Hold every stage while the output beat is not taken
  assign en        = ~vld[NSTG-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // ---- stage 1: max, min, hue numerator, saturation numerator, value
  logic [CHAN_W-1:0] mx, mn, dl;
  logic signed [CHAN_W:0] diff;
  logic [CHAN_W-1:0] mag;
  logic [HUE_W-1:0]  hoff;

  logic [19:0]          s1_hnum;
  logic                 s1_hneg, s1_hzero;
  logic [HUE_W-1:0]     s1_hoff;
  logic [DIV_NUM_W-1:0] s1_snum;
  logic [CHAN_W-1:0]    s1_mx, s1_dl;
  logic [FRAC_W-1:0]    s1_v;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    dl = mx - mn;
    if (mx == in_red) begin
      diff = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
      hoff = '0;
    end else if (mx == in_green) begin
      diff = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
      hoff = HUE_120;
    end else begin
      diff = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
      hoff = HUE_240;
    end
    mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hnum  <= 20'(mag) * 20'(HUE_60);
      s1_hneg  <= diff[CHAN_W];
      s1_hzero <= (dl == '0);
      s1_hoff  <= hoff;
      s1_snum  <= {dl, 16'h0000} - DIV_NUM_W'(dl);
      s1_mx    <= mx;
      s1_dl    <= dl;
      s1_v     <= {mx, 8'h00} + FRAC_W'(mx);
    end
  end

  // ---- divider stages
  logic [DIV_NUM_W-1:0] qh, qs;

  hsvsb_div #(.NUM_W(DIV_NUM_W), .BPS(DIV_BITS_PER_STAGE)) u_div_hue (
    .clk (clk), .en (en), .num (DIV_NUM_W'(s1_hnum)), .den (s1_dl), .quo (qh)
  );

  hsvsb_div #(.NUM_W(DIV_NUM_W), .BPS(DIV_BITS_PER_STAGE)) u_div_sat (
    .clk (clk), .en (en), .num (s1_snum), .den (s1_mx), .quo (qs)
  );

  logic [DIV_STG-1:0]             sd_hneg, sd_hzero, sd_mxz;
  logic [DIV_STG-1:0][HUE_W-1:0]  sd_hoff;
  logic [DIV_STG-1:0][FRAC_W-1:0] sd_v;

  always_ff @(posedge clk) begin
    if (en) begin
      sd_hneg[0]  <= s1_hneg;
      sd_hzero[0] <= s1_hzero;
      sd_mxz[0]   <= (s1_mx == '0);
      sd_hoff[0]  <= s1_hoff;
      sd_v[0]     <= s1_v;
      for (int s = 1; s < DIV_STG; s++) begin
        sd_hneg[s]  <= sd_hneg[s-1];
        sd_hzero[s] <= sd_hzero[s-1];
        sd_mxz[s]   <= sd_mxz[s-1];
        sd_hoff[s]  <= sd_hoff[s-1];
        sd_v[s]     <= sd_v[s-1];
      end
    end
  end

  // ---- stage A: finish hue, multiply the selected component by the gain factor
  logic signed [16:0] hs;
  logic [HUE_W-1:0]   hfin;
  logic [FRAC_W-1:0]  sval, xsel;
  logic signed [12:0] factor;

  logic [HUE_W-1:0]   pa_h;
  logic signed [29:0] pa_prod;
  logic [FRAC_W-1:0]  pa_s, pa_v;

  always_comb begin
    if (sd_hneg[DIV_STG-1])
      hs = $signed({2'b00, sd_hoff[DIV_STG-1]}) - $signed({5'b0, qh[11:0]});
    else
      hs = $signed({2'b00, sd_hoff[DIV_STG-1]}) + $signed({5'b0, qh[11:0]});
    if (hs < 0)
      hs = hs + $signed({2'b00, HUE_360});
    hfin   = sd_hzero[DIV_STG-1] ? '0 : hs[HUE_W-1:0];
    sval   = sd_mxz[DIV_STG-1] ? '0 : qs[FRAC_W-1:0];
    xsel   = adjust_mode ? sd_v[DIV_STG-1] : sval;
    factor = 13'sd256 + 13'(gain_q8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_h    <= hfin;
      pa_prod <= 30'($signed({1'b0, xsel})) * 30'(factor);
      pa_s    <= sval;
      pa_v    <= sd_v[DIV_STG-1];
    end
  end

  // ---- stage B: clamp the scaled component, find the hue sextant
  logic [FRAC_W-1:0] scaled;
  logic [21:0]       p8;
  logic [2:0]        kk;

  logic [FRAC_W-1:0] pb_s, pb_v;
  logic [HUE_W-1:0]  pb_h;
  logic [2:0]        pb_k;

  always_comb begin
    p8 = pa_prod[29:8];
    if (pa_prod <= 0)
      scaled = '0;
    else if (p8 > 22'd65535)
      scaled = 16'hFFFF;
    else
      scaled = p8[FRAC_W-1:0];
    if (pa_h < HUE_60)                kk = 3'd0;
    else if (pa_h < HUE_120)          kk = 3'd1;
    else if (pa_h < 15'd11520)        kk = 3'd2;
    else if (pa_h < HUE_240)          kk = 3'd3;
    else if (pa_h < 15'd19200)        kk = 3'd4;
    else if (pa_h < HUE_360)          kk = 3'd5;
    else                              kk = 3'd6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_s <= adjust_mode ? pa_s : scaled;
      pb_v <= adjust_mode ? scaled : pa_v;
      pb_h <= pa_h;
      pb_k <= kk;
    end
  end

  // ---- stage C: V*S, hue fraction within the sextant pair
  logic [HUE_W-1:0] fpos, dd;

  logic [31:0] pc_pvs;
  logic [FRAC_W-1:0] pc_v;
  logic [2:0]  pc_k;
  logic [11:0] pc_w;

  always_comb begin
    case (pb_k[2:1])
      2'd0:    fpos = pb_h;
      2'd1:    fpos = pb_h - HUE_120;
      2'd2:    fpos = pb_h - HUE_240;
      default: fpos = pb_h;
    endcase
    dd = (fpos >= HUE_60) ? fpos - HUE_60 : HUE_60 - fpos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_pvs <= 32'(pb_v) * 32'(pb_s);
      pc_v   <= pb_v;
      pc_k   <= pb_k;
      pc_w   <= 12'(HUE_60 - dd);
    end
  end

  // ---- stage D: C = floor(V*S / 65535), one correction step
  logic [16:0]       rr;
  logic [FRAC_W-1:0] q0;

  logic [FRAC_W-1:0] pd_c, pd_v;
  logic [2:0]        pd_k;
  logic [11:0]       pd_w;

  always_comb begin
    q0 = pc_pvs[31:16];
    rr = {1'b0, pc_pvs[15:0]} + 17'(q0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_c <= (rr >= 17'd65535) ? q0 + 16'd1 : q0;
      pd_v <= pc_v;
      pd_k <= pc_k;
      pd_w <= pc_w;
    end
  end

  // ---- stage E: C * (3840 - d)
  logic [27:0]       pe_pcx;
  logic [FRAC_W-1:0] pe_c, pe_m;
  logic [2:0]        pe_k;

  always_ff @(posedge clk) begin
    if (en) begin
      pe_pcx <= 28'(pd_c) * 28'(pd_w);
      pe_c   <= pd_c;
      pe_m   <= pd_v - pd_c;
      pe_k   <= pd_k;
    end
  end

  // ---- stage F: divide by 3840 as shift by 8 then reciprocal of 15
  logic [40:0]       pf_qx;
  logic [FRAC_W-1:0] pf_c, pf_m;
  logic [2:0]        pf_k;

  always_ff @(posedge clk) begin
    if (en) begin
      pf_qx <= 41'(pe_pcx[27:8]) * 41'(RECIP_15);
      pf_c  <= pe_c;
      pf_m  <= pe_m;
      pf_k  <= pe_k;
    end
  end

  // ---- stage G: place chroma parts by sextant, add the offset m
  logic [FRAC_W-1:0] xv, pr, pg, pbl;
  logic [FRAC_W-1:0] pg_r, pg_g, pg_b;

  always_comb begin
    xv = pf_qx[39:24];
    case (pf_k)
      3'd0:    begin pr = pf_c; pg = xv;   pbl = '0;   end
      3'd1:    begin pr = xv;   pg = pf_c; pbl = '0;   end
      3'd2:    begin pr = '0;   pg = pf_c; pbl = xv;   end
      3'd3:    begin pr = '0;   pg = xv;   pbl = pf_c; end
      3'd4:    begin pr = xv;   pg = '0;   pbl = pf_c; end
      3'd5:    begin pr = pf_c; pg = '0;   pbl = xv;   end
      default: begin pr = '0;   pg = '0;   pbl = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg_r <= pr + pf_m;
      pg_g <= pg + pf_m;
      pg_b <= pbl + pf_m;
    end
  end

  // ---- stage H: times reciprocal of 257 (255/65535 = 1/257)
  logic [32:0] ph_r, ph_g, ph_b;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= 33'(pg_r) * 33'(RECIP_257);
      ph_g <= 33'(pg_g) * 33'(RECIP_257);
      ph_b <= 33'(pg_b) * 33'(RECIP_257);
    end
  end

  // ---- stage I: output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_red   <= ph_r[31:24];
      out_green <= ph_g[31:24];
      out_blue  <= ph_b[31:24];
    end
  end

endmodule

>>> src/hsvsb_div.sv
// ----------------------------------------------------------------------------
// hsvsb_div
// Pipelined restoring divider, BPS quotient bits per stage.
// ----------------------------------------------------------------------------
module hsvsb_div
  import hsvsb_pkg::*;
#(
  parameter int unsigned NUM_W = DIV_NUM_W,
  parameter int unsigned BPS   = DIV_BPS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_W-1:0]     num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [NUM_W-1:0]     quo
);

  localparam int unsigned STG = (NUM_W + BPS - 1) / BPS;
  localparam int unsigned PW  = STG * BPS;

  logic [STG-1:0][DIV_DEN_W-1:0] rem;
  logic [STG-1:0][DIV_DEN_W-1:0] rem_next;
  logic [STG-1:0][PW-1:0]        nsh;
  logic [STG-1:0][PW-1:0]        nsh_next;
  logic [STG-1:0][PW-1:0]        qb;
  logic [STG-1:0][PW-1:0]        qb_next;
  logic [STG-1:0][DIV_DEN_W-1:0] dq;
  logic [STG-1:0][DIV_DEN_W-1:0] dq_next;

  always_comb begin
    logic [DIV_DEN_W-1:0] r;
    logic [DIV_DEN_W:0]   t;
    logic [PW-1:0]        n;
    logic [PW-1:0]        q;
    logic [DIV_DEN_W-1:0] d;
    for (int s = 0; s < STG; s++) begin
      if (s == 0) begin
        r = '0;
        n = PW'(num);
        q = '0;
        d = den;
      end else begin
        r = rem[s-1];
        n = nsh[s-1];
        q = qb[s-1];
        d = dq[s-1];
      end
      for (int i = 0; i < BPS; i++) begin
        t = {r, n[PW-1]};
        n = {n[PW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[PW-2:0], 1'b1};
        end else begin
          q = {q[PW-2:0], 1'b0};
        end
        r = t[DIV_DEN_W-1:0];
      end
      rem_next[s] = r;
      nsh_next[s] = n;
      qb_next[s]  = q;
      dq_next[s]  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      nsh <= nsh_next;
      qb  <= qb_next;
      dq  <= dq_next;
    end
  end

  assign quo = qb[STG-1][NUM_W-1:0];

endmodule

>>> verif/hsv_saturation_brightness_adjust_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_saturation_brightness_adjust_unit_tb
// Streams BGR pixels through the adjust unit under several mode and gain
// settings, predicts each adjusted pixel in fixed point and compares it with
// the output beats, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module hsv_saturation_brightness_adjust_unit_tb;
  import hsvsb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_blue;
  logic [CHAN_W-1:0]    in_green;
  logic [CHAN_W-1:0]    in_red;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_red;

  pixel_t expected_pixels[$];
  int     errors;
  bit     mode_value;
  int     gain_value;
  bit     hold_off;
  int     stall_pct;
  int     gap_pct;

  hsv_saturation_brightness_adjust_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint scale_frac(longint x);
    longint p;
    p = x * (256 + gain_value);
    if (p <= 0) return 0;
    p = p / 256;
    return (p > 65535) ? 65535 : p;
  endfunction

  function automatic logic [7:0] to_chan(longint x);
    longint c;
    c = (x * 255) / 65535;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t px);
    int r, g, b, mx, mn, dl, h;
    longint s, v, c, f, d, x, m, pr, pg, pb;
    pixel_t res;
    r = px.red; g = px.green; b = px.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    // SV int division truncates toward zero, as required for the red sextant
    if (dl == 0) h = 0;
    else if (mx == r) h = (3840 * (g - b)) / dl;
    else if (mx == g) h = (3840 * (b - r)) / dl + 7680;
    else h = (3840 * (r - g)) / dl + 15360;
    if (h < 0) h += 23040;
    s = (mx == 0) ? 0 : (longint'(dl) * 65535) / mx;
    v = longint'(mx) * 257;
    if (!mode_value) s = scale_frac(s);
    else v = scale_frac(v);
    c = (v * s) / 65535;
    f = h % 7680;
    d = (f >= 3840) ? f - 3840 : 3840 - f;
    x = (c * (3840 - d)) / 3840;
    m = v - c;
    case (h / 3840)
      0: begin pr = c; pg = x; pb = 0; end
      1: begin pr = x; pg = c; pb = 0; end
      2: begin pr = 0; pg = c; pb = x; end
      3: begin pr = 0; pg = x; pb = c; end
      4: begin pr = x; pg = 0; pb = c; end
      5: begin pr = c; pg = 0; pb = x; end
      default: begin pr = 0; pg = 0; pb = 0; end
    endcase
    res.blue = to_chan(pb + m);
    res.green = to_chan(pg + m);
    res.red = to_chan(pr + m);
    return res;
  endfunction

  // Receiver: random stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output beat %h %h %h", out_blue, out_green, out_red);
        errors++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_blue !== exp_px.blue) begin
          $error("out_blue expected %0d actual %0d", exp_px.blue, out_blue);
          errors++;
        end
        if (out_green !== exp_px.green) begin
          $error("out_green expected %0d actual %0d", exp_px.green, out_green);
          errors++;
        end
        if (out_red !== exp_px.red) begin
          $error("out_red expected %0d actual %0d", exp_px.red, out_red);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(pixel_t px);
    in_blue  <= px.blue;
    in_green <= px.green;
    in_red   <= px.red;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(adjust_pixel(px));
    @(negedge clk);
  endtask

  // Bursts of back-to-back beats separated by random gaps
  task automatic send_burst(pixel_t px[$]);
    int burst;
    burst = 0;
    foreach (px[i]) begin
      if (burst == 0) begin
        if ($urandom_range(99) < gap_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      send_pixel(px[i]);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ADJUST_MODE) mode_value = data[0];
    else if (idx == REG_GAIN_Q8) gain_value = $signed(data);
    @(negedge clk);
  endtask

  task automatic set_mode_gain(bit mode, int gain);
    write_reg(REG_ADJUST_MODE, GAIN_W'(mode));
    write_reg(REG_GAIN_Q8, GAIN_W'(gain));
    cfg_valid <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = 24'($urandom);
    return px;
  endfunction

  task automatic test_directed_pixels();
    pixel_t q[$];
    q = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
          '{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd0},
          '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd255},
          '{8'd255, 8'd1, 8'd254}, '{8'd1, 8'd254, 8'd255}, '{8'd0, 8'd1, 8'd1},
          '{8'd170, 8'd85, 8'd0}, '{8'd10, 8'd200, 8'd90}, '{8'd254, 8'd1, 8'd0},
          '{8'd55, 8'd170, 8'd170}, '{8'd1, 8'd0, 8'd0}, '{8'd200, 8'd100, 8'd250}};
    foreach (q[i]) send_pixel(q[i]);
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic test_gain_settings();
    int gains[8] = '{0, -256, 1024, -2048, 2047, 128, -100, 512};
    pixel_t q[$];
    for (int md = 0; md < 2; md++) begin
      foreach (gains[i]) begin
        set_mode_gain(md[0], gains[i]);
        stall_pct = (i % 3 == 0) ? 0 : $urandom_range(10, 60);
        gap_pct   = (i % 3 == 1) ? 0 : $urandom_range(10, 60);
        q = {};
        repeat (100) q.push_back(rand_pixel());
        send_burst(q);
        drain();
      end
    end
  endtask

  task automatic test_backpressure();
    pixel_t q[$];
    set_mode_gain(1'b0, $urandom_range(0, 1024));
    gap_pct = 0;
    stall_pct = 20;
    repeat (120) q.push_back(rand_pixel());
    fork
      send_burst(q);
      begin
        hold_off = 1'b1;
        repeat (80) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random_gain();
    pixel_t q[$];
    repeat (4) begin
      set_mode_gain($urandom_range(1), int'($urandom_range(0, 4095)) - 2048);
      q = {};
      repeat (40) q.push_back(rand_pixel());
      send_burst(q);
      drain();
    end
  endtask

  initial begin
    errors = 0;
    mode_value = 1'b0;
    gain_value = 0;
    hold_off = 1'b0;
    stall_pct = 30;
    gap_pct = 30;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_ADJUST_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_blue = '0;
    in_green = '0;
    in_red = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_pixels();
    test_gain_settings();
    test_backpressure();
    test_random_gain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
